@@ hw/rtl/sm3_hash_engine_assert.svh @@
// Assertion macros for the SM3 engine checker.
`ifndef SM3_HASH_ENGINE_ASSERT_SVH
`define SM3_HASH_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SM3_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sm3 check failed");

// Next-cycle implication.
`define SM3_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sm3 check failed");

`endif

@@ hw/rtl/sm3_pkg.sv @@
`timescale 1ns / 1ps
package sm3_pkg;

  localparam int unsigned BlkBytes = 64;
  localparam int unsigned LenPos   = 56;

  localparam logic [7:0]  PadByte = 8'h80;
  localparam logic [31:0] TLow    = 32'h79cc4519;
  localparam logic [31:0] THigh   = 32'h7a879d8a;

  localparam logic [31:0] Iv [8] = '{
    32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
    32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
  };

  // Rotate left by 0..31
  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] r);
    logic [63:0] dbl;
    dbl = {x, x} << r;
    return dbl[63:32];
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rotl32(x, 5'd15) ^ rotl32(x, 5'd23);
  endfunction

endpackage

@@ hw/rtl/sm3_hash_engine.sv @@
`timescale 1ns / 1ps
// SM3 engine: one byte of an item is written into the block store per cycle while no block
// is being compressed; a new item is accepted only after all bytes of the last are written.
// A full 64-byte block is read from the store word by word, then compressed in 64 rounds.
// The last item adds padding bytes (one per cycle outside compression, up to two compressions),
// then eight digest items follow, one per cycle when not stalled. Input is stalled meanwhile.
// rst_ni (async, low) loads the IV and clears length, fill level and control state.
module sm3_hash_engine
  import sm3_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        msg_valid_i,
  output logic        msg_stall_o,
  input  logic [31:0] msg_word_i,
  input  logic [2:0]  byte_count_i,
  input  logic        end_of_message_i,
  output logic        digest_valid_o,
  input  logic        digest_stall_i,
  output logic [31:0] digest_word_o,
  output logic        digest_last_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PUSH, ST_LOAD, ST_ROUND, ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    PAD_NONE, PAD_80, PAD_ZERO, PAD_LEN, PAD_DONE
  } pad_e;

  state_e       state_q, state_d;
  pad_e         pad_q, pad_d;
  logic [31:0]  word_q, word_d;
  logic [2:0]   nleft_q, nleft_d;
  logic [2:0]   lcnt_q, lcnt_d;
  logic [5:0]   fill_q, fill_d;
  logic [63:0]  len_q, len_d;
  logic [4:0]   ld_cnt_q, ld_cnt_d;
  logic [5:0]   rnd_q, rnd_d;
  logic [2:0]   idx_q, idx_d;
  logic [31:0]  cv_q [8];
  logic [31:0]  cv_d [8];
  logic [31:0]  wv_q [8];
  logic [31:0]  wv_d [8];
  logic [31:0]  win_q [16];
  logic [31:0]  win_d [16];

  // Block store: four byte lanes of 16 entries, one word read per cycle
  logic [7:0]   blk_mem [4][16];
  logic         wr_en;
  logic [7:0]   wr_byte;
  logic [31:0]  rdata_q;

  logic         in_acc, out_acc;
  logic [2:0]   n_sat;

  // Round datapath
  logic [31:0]  a12, tj, ss1, ss2, ff, gg, tt1, tt2, w_new;
  logic         hi_rnd;

  assign msg_stall_o    = (state_q != ST_IDLE);
  assign in_acc         = msg_valid_i && !msg_stall_o;
  assign digest_valid_o = (state_q == ST_OUT);
  assign digest_word_o  = cv_q[idx_q];
  assign digest_last_o  = (state_q == ST_OUT) && (idx_q == 3'd7);
  assign out_acc        = digest_valid_o && !digest_stall_i;
  assign n_sat          = (byte_count_i > 3'd4) ? 3'd4 : byte_count_i;

  // One SM3 round on the working variables
  always_comb begin
    hi_rnd = (rnd_q >= 6'd16);
    a12    = rotl32(wv_q[0], 5'd12);
    tj     = rotl32(hi_rnd ? THigh : TLow, rnd_q[4:0]);
    ss1    = rotl32(a12 + wv_q[4] + tj, 5'd7);
    ss2    = ss1 ^ a12;
    if (hi_rnd) begin
      ff = (wv_q[0] & wv_q[1]) | (wv_q[0] & wv_q[2]) | (wv_q[1] & wv_q[2]);
      gg = (wv_q[4] & wv_q[5]) | (~wv_q[4] & wv_q[6]);
    end else begin
      ff = wv_q[0] ^ wv_q[1] ^ wv_q[2];
      gg = wv_q[4] ^ wv_q[5] ^ wv_q[6];
    end
    tt1   = ff + wv_q[3] + ss2 + (win_q[0] ^ win_q[4]);
    tt2   = gg + wv_q[7] + ss1 + win_q[0];
    w_new = perm1(win_q[0] ^ win_q[7] ^ rotl32(win_q[13], 5'd15))
            ^ rotl32(win_q[3], 5'd7) ^ win_q[10];
  end

  // Next-state logic
  always_comb begin
    state_d  = state_q;
    pad_d    = pad_q;
    word_d   = word_q;
    nleft_d  = nleft_q;
    lcnt_d   = lcnt_q;
    fill_d   = fill_q;
    len_d    = len_q;
    ld_cnt_d = ld_cnt_q;
    rnd_d    = rnd_q;
    idx_d    = idx_q;
    cv_d     = cv_q;
    wv_d     = wv_q;
    win_d    = win_q;
    wr_en    = 1'b0;
    wr_byte  = 8'h00;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          word_d  = msg_word_i;
          nleft_d = n_sat;
          pad_d   = end_of_message_i ? PAD_80 : PAD_NONE;
          state_d = ST_PUSH;
        end
      end

      ST_PUSH: begin
        if (nleft_q != 3'd0) begin
          wr_en   = 1'b1;
          wr_byte = word_q[31:24];
          word_d  = {word_q[23:0], 8'h00};
          nleft_d = nleft_q - 3'd1;
          len_d   = len_q + 64'd8;
        end else begin
          case (pad_q)
            PAD_80: begin
              wr_en   = 1'b1;
              wr_byte = PadByte;
              pad_d   = PAD_ZERO;
            end
            PAD_ZERO: begin
              if (fill_q == 6'(LenPos)) begin
                pad_d  = PAD_LEN;
                lcnt_d = 3'd0;
              end else begin
                wr_en = 1'b1;
              end
            end
            PAD_LEN: begin
              wr_en   = 1'b1;
              wr_byte = len_q[{~lcnt_q, 3'b000} +: 8];
              lcnt_d  = lcnt_q + 3'd1;
              if (lcnt_q == 3'd7) pad_d = PAD_DONE;
            end
            default: state_d = ST_IDLE;
          endcase
        end
        // Full block goes to compression
        if (wr_en) begin
          if (fill_q == 6'(BlkBytes - 1)) begin
            fill_d   = 6'd0;
            ld_cnt_d = 5'd0;
            state_d  = ST_LOAD;
          end else begin
            fill_d = fill_q + 6'd1;
          end
        end
      end

      ST_LOAD: begin
        ld_cnt_d = ld_cnt_q + 5'd1;
        if (ld_cnt_q != 5'd0) begin
          for (int i = 0; i < 15; i++) win_d[i] = win_q[i + 1];
          win_d[15] = rdata_q;
        end
        if (ld_cnt_q == 5'd16) begin
          wv_d    = cv_q;
          rnd_d   = 6'd0;
          state_d = ST_ROUND;
        end
      end

      ST_ROUND: begin
        // Expansion window slides one word per round
        for (int i = 0; i < 15; i++) win_d[i] = win_q[i + 1];
        win_d[15] = w_new;
        wv_d[0] = tt1;
        wv_d[1] = wv_q[0];
        wv_d[2] = rotl32(wv_q[1], 5'd9);
        wv_d[3] = wv_q[2];
        wv_d[4] = perm0(tt2);
        wv_d[5] = wv_q[4];
        wv_d[6] = rotl32(wv_q[5], 5'd19);
        wv_d[7] = wv_q[6];
        rnd_d   = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          for (int i = 0; i < 8; i++) cv_d[i] = cv_q[i] ^ wv_d[i];
          if (pad_q == PAD_DONE) begin
            idx_d   = 3'd0;
            state_d = ST_OUT;
          end else begin
            state_d = ST_PUSH;
          end
        end
      end

      ST_OUT: begin
        if (out_acc) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            cv_d    = Iv;
            len_d   = 64'd0;
            fill_d  = 6'd0;
            pad_d   = PAD_NONE;
            state_d = ST_IDLE;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // State and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      pad_q    <= PAD_NONE;
      word_q   <= '0;
      nleft_q  <= '0;
      lcnt_q   <= '0;
      fill_q   <= '0;
      len_q    <= '0;
      ld_cnt_q <= '0;
      rnd_q    <= '0;
      idx_q    <= '0;
      cv_q     <= Iv;
      for (int i = 0; i < 8; i++) wv_q[i] <= '0;
      for (int i = 0; i < 16; i++) win_q[i] <= '0;
    end else begin
      state_q  <= state_d;
      pad_q    <= pad_d;
      word_q   <= word_d;
      nleft_q  <= nleft_d;
      lcnt_q   <= lcnt_d;
      fill_q   <= fill_d;
      len_q    <= len_d;
      ld_cnt_q <= ld_cnt_d;
      rnd_q    <= rnd_d;
      idx_q    <= idx_d;
      cv_q     <= cv_d;
      wv_q     <= wv_d;
      win_q    <= win_d;
    end
  end

  // Block store: byte write, registered word read
  always_ff @(posedge clk_i) begin
    if (wr_en) blk_mem[fill_q[1:0]][fill_q[5:2]] <= wr_byte;
    rdata_q <= {blk_mem[0][ld_cnt_q[3:0]], blk_mem[1][ld_cnt_q[3:0]],
                blk_mem[2][ld_cnt_q[3:0]], blk_mem[3][ld_cnt_q[3:0]]};
  end

endmodule

@@ hw/rtl/sm3_chk.sv @@
`timescale 1ns / 1ps
`include "sm3_hash_engine_assert.svh"
module sm3_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        msg_valid_i,
  input logic        msg_stall_o,
  input logic [31:0] msg_word_i,
  input logic [2:0]  byte_count_i,
  input logic        end_of_message_i,
  input logic        digest_valid_o,
  input logic        digest_stall_i,
  input logic [31:0] digest_word_o,
  input logic        digest_last_o
);

  // No new item while the digest is being delivered
  `SM3_ASSERT_NOW(a_busy_out, digest_valid_o, msg_stall_o)
  // The digest burst ends right after its last item
  `SM3_ASSERT_NEXT(a_burst_end, digest_valid_o && !digest_stall_i && digest_last_o, !digest_valid_o)
  // A burst starts at word 0, never on the last one
  `SM3_ASSERT_NOW(a_burst_start, $rose(digest_valid_o), !digest_last_o)
  // Stalled digest item holds
  `SM3_ASSERT_NEXT(a_hold, digest_valid_o && digest_stall_i, digest_valid_o && $stable(digest_word_o))
  // Stalled input item holds
  `SM3_ASSERT_NEXT(a_in_hold, msg_valid_i && msg_stall_o, msg_valid_i && $stable({msg_word_i, byte_count_i, end_of_message_i}))

endmodule

bind sm3_hash_engine sm3_chk u_sm3_chk (.*);
